FILE: design/mrb_pkg.sv
// ----------------------------------------------------------------------------
// Multitouch report builder package
// Shared types and constants for the report builder controller and datapath.
// ----------------------------------------------------------------------------
package mrb_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned RID_W     = 8;
  localparam int unsigned ACT_W     = 3;

  localparam logic [RID_W-1:0] RID_RESET = 8'd1;
  localparam logic [ACT_W-1:0] ACT_SAT   = 3'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REPORT  = 2'd2
  } mrb_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } mrb_state_e;

  typedef struct packed {
    logic accept;
    logic emit;
  } mrb_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_report;
    logic out_free;
    logic slot_last;
  } mrb_status_t;

endpackage

FILE: design/mrb_ctrl.sv
// ----------------------------------------------------------------------------
// Multitouch report builder controller
// Sequences command acceptance and the slot-by-slot emission of a report.
// ----------------------------------------------------------------------------
module mrb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrb_pkg::mrb_status_t status_i,
  output mrb_pkg::mrb_ctrl_t   ctrl_o,
  output logic                in_ready_o
);
  import mrb_pkg::*;

  mrb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid && status_i.is_report) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (status_i.out_free && status_i.slot_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ctrl_o.accept = 1'b0;
    ctrl_o.emit   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = status_i.in_valid;
      end
      ST_REPORT: begin
        ctrl_o.emit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_emit_only_in_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.emit |-> (state_q == ST_REPORT) && !in_ready_o)
    else $error("Slot emitted outside a report.");

  a_last_slot_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.emit && status_i.slot_last) |=> (state_q == ST_IDLE))
    else $error("Controller did not return to idle after the final slot.");

endmodule

FILE: design/mrb_dp.sv
// ----------------------------------------------------------------------------
// Multitouch report builder datapath
// Contact table, active count, report slot walker and the output register.
// ----------------------------------------------------------------------------
module mrb_dp #(
  parameter int unsigned MAX_CONTACTS = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mrb_pkg::mrb_ctrl_t                ctrl_i,
  output mrb_pkg::mrb_status_t              status_o,
  input  logic                              in_valid_i,
  input  logic [mrb_pkg::CMD_W-1:0]         cmd_i,
  input  logic [mrb_pkg::ID_W-1:0]          contact_id_i,
  input  logic [mrb_pkg::COORD_W-1:0]       pos_x_i,
  input  logic [mrb_pkg::COORD_W-1:0]       pos_y_i,
  input  logic [mrb_pkg::TIME_W-1:0]        scan_ms_i,
  input  logic                              cfg_valid_i,
  input  logic [mrb_pkg::RID_W-1:0]         cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mrb_pkg::RID_W-1:0]         out_report_id_o,
  output logic                              slot_tip_o,
  output logic [mrb_pkg::ID_W-1:0]          slot_contact_o,
  output logic [mrb_pkg::COORD_W-1:0]       slot_x_o,
  output logic [mrb_pkg::COORD_W-1:0]       slot_y_o,
  output logic [mrb_pkg::TIME_W-1:0]        scan_units_o,
  output logic [mrb_pkg::ACT_W-1:0]         active_count_o,
  output logic                              last_slot_o
);
  import mrb_pkg::*;

  localparam int unsigned IDX_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CONTACTS + 1);
  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(MAX_CONTACTS - 1);

  logic [RID_W-1:0]        rid_q;
  logic [MAX_CONTACTS-1:0] active_q, active_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [COORD_W-1:0]      xs_q [MAX_CONTACTS];
  logic [COORD_W-1:0]      ys_q [MAX_CONTACTS];
  logic [MAX_CONTACTS-1:0] pend_q, pend_d;
  logic [IDX_W-1:0]        slot_q, slot_d;
  logic [TIME_W-1:0]       units_q;
  logic [ACT_W-1:0]        act_q;
  logic                    out_valid_q, out_valid_d;

  logic [RID_W-1:0]   o_rid_q;
  logic               o_tip_q;
  logic [ID_W-1:0]    o_contact_q;
  logic [COORD_W-1:0] o_x_q, o_y_q;
  logic [TIME_W-1:0]  o_units_q;
  logic [ACT_W-1:0]   o_act_q;
  logic               o_last_q;

  logic                    id_ok;
  logic [IDX_W-1:0]        wr_idx;
  logic [MAX_CONTACTS-1:0] low_bit;
  logic [IDX_W-1:0]        rd_idx;
  logic [ACT_W-1:0]        act_sat;
  logic [TIME_W-1:0]       units_calc;

  assign id_ok  = contact_id_i < ID_W'(MAX_CONTACTS);
  assign wr_idx = contact_id_i[IDX_W-1:0];

  assign low_bit    = pend_q & (~pend_q + MAX_CONTACTS'(1));
  assign units_calc = (scan_ms_i << 3) + (scan_ms_i << 1);
  assign act_sat    = (32'(count_q) > 32'(ACT_SAT)) ? ACT_SAT : ACT_W'(count_q);

  always_comb begin
    rd_idx = '0;
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      if (low_bit[i]) begin
        rd_idx = rd_idx | IDX_W'(i);
      end
    end
  end

  assign status_o.in_valid  = in_valid_i;
  assign status_o.is_report = (cmd_i == CMD_REPORT);
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.slot_last = (slot_q == SLOT_LAST);

  always_comb begin
    active_d = active_q;
    count_d  = count_q;
    if (ctrl_i.accept && id_ok) begin
      case (cmd_i)
        CMD_SET: begin
          active_d[wr_idx] = 1'b1;
          if (!active_q[wr_idx]) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        CMD_RELEASE: begin
          active_d[wr_idx] = 1'b0;
          if (active_q[wr_idx]) begin
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_comb begin
    pend_d      = pend_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    if (ctrl_i.accept && (cmd_i == CMD_REPORT)) begin
      pend_d = active_q;
      slot_d = '0;
    end else if (ctrl_i.emit) begin
      pend_d = pend_q & ~low_bit;
      slot_d = status_o.slot_last ? '0 : slot_q + IDX_W'(1);
    end
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rid_q       <= RID_RESET;
      active_q    <= '0;
      count_q     <= '0;
      pend_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rid_q <= cfg_data_i;
      end
      active_q    <= active_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && (cmd_i == CMD_SET) && id_ok) begin
      xs_q[wr_idx] <= pos_x_i;
      ys_q[wr_idx] <= pos_y_i;
    end
    if (ctrl_i.accept && (cmd_i == CMD_REPORT)) begin
      units_q <= units_calc;
      act_q   <= act_sat;
    end
    if (ctrl_i.emit) begin
      o_rid_q   <= rid_q;
      o_units_q <= units_q;
      o_act_q   <= act_q;
      o_last_q  <= status_o.slot_last;
      if (pend_q != '0) begin
        o_tip_q     <= 1'b1;
        o_contact_q <= ID_W'(rd_idx);
        o_x_q       <= xs_q[rd_idx];
        o_y_q       <= ys_q[rd_idx];
      end else begin
        o_tip_q     <= 1'b0;
        o_contact_q <= '0;
        o_x_q       <= '0;
        o_y_q       <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_report_id_o = o_rid_q;
  assign slot_tip_o      = o_tip_q;
  assign slot_contact_o  = o_contact_q;
  assign slot_x_o        = o_x_q;
  assign slot_y_o        = o_y_q;
  assign scan_units_o    = o_units_q;
  assign active_count_o  = o_act_q;
  assign last_slot_o     = o_last_q;

  a_count_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(active_q) == 32'(count_q))
    else $error("Active count does not match the contact flags.");

  a_pending_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> ((pend_q & ~active_q) == '0))
    else $error("Pending slot mask holds an inactive contact.");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |=> out_valid_q && (o_tip_q == $past(pend_q != '0)))
    else $error("Output register was not loaded by an emitted slot.");

endmodule

FILE: design/multitouch_report_builder.sv
// ----------------------------------------------------------------------------
// Multitouch report builder
// Keeps a table of touch contacts and emits compacted digitiser reports.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Word
//  in       input      in_valid_i / in_ready_o    cmd, contact id, x, y, scan ms
//  out      output     out_valid_o / out_ready_i  one report slot
//  cfg      input      cfg_valid_i / cfg_ready_o  report id
//
// Set and release words leave the controller idle and ready for the next word.
// A report word moves the controller to its report state, where the slot counter
// emits MAX_CONTACTS slots, one a cycle while the output is free, through the output register.
// Reset clears every contact flag and sets the report id to one.
// A stalled output holds the slot walker; the input is taken again once the
// final slot has entered the output register.
// ----------------------------------------------------------------------------
module multitouch_report_builder #(
  parameter int unsigned MAX_CONTACTS = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mrb_pkg::CMD_W-1:0]   cmd_i,
  input  logic [mrb_pkg::ID_W-1:0]    contact_id_i,
  input  logic [mrb_pkg::COORD_W-1:0] pos_x_i,
  input  logic [mrb_pkg::COORD_W-1:0] pos_y_i,
  input  logic [mrb_pkg::TIME_W-1:0]  scan_ms_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mrb_pkg::RID_W-1:0]   cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mrb_pkg::RID_W-1:0]   out_report_id_o,
  output logic                        slot_tip_o,
  output logic [mrb_pkg::ID_W-1:0]    slot_contact_o,
  output logic [mrb_pkg::COORD_W-1:0] slot_x_o,
  output logic [mrb_pkg::COORD_W-1:0] slot_y_o,
  output logic [mrb_pkg::TIME_W-1:0]  scan_units_o,
  output logic [mrb_pkg::ACT_W-1:0]   active_count_o,
  output logic                        last_slot_o
);
  import mrb_pkg::*;

  mrb_ctrl_t   ctrl;
  mrb_status_t status;

  assign cfg_ready_o = 1'b1;

  mrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  mrb_dp #(
    .MAX_CONTACTS (MAX_CONTACTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .in_valid_i      (in_valid_i),
    .cmd_i           (cmd_i),
    .contact_id_i    (contact_id_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .scan_ms_i       (scan_ms_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_report_id_o (out_report_id_o),
    .slot_tip_o      (slot_tip_o),
    .slot_contact_o  (slot_contact_o),
    .slot_x_o        (slot_x_o),
    .slot_y_o        (slot_y_o),
    .scan_units_o    (scan_units_o),
    .active_count_o  (active_count_o),
    .last_slot_o     (last_slot_o)
  );

endmodule

FILE: bench/tb_multitouch_report_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multitouch report builder testbench
// Sends set, release and report words to the contact table and checks every
// emitted slot against a predicted copy of the table. A directed sequence is
// followed by three random phases with different report ids and different
// amounts of idling on the input and output channels.
// ----------------------------------------------------------------------------
module tb_multitouch_report_builder;
  import mrb_pkg::*;

  localparam int unsigned N_CONTACTS = 5;
  localparam int unsigned SCAN_SCALE = 10;
  localparam int unsigned SETTLE_CYCLES = N_CONTACTS + 3;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [RID_W-1:0]   rid;
    logic               tip;
    logic [ID_W-1:0]    contact;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  units;
    logic [ACT_W-1:0]   count;
    logic               last;
  } slot_t;

  class report_predictor;
    logic [RID_W-1:0]   cur_rid;
    bit                 touching [N_CONTACTS];
    logic [COORD_W-1:0] held_x [N_CONTACTS];
    logic [COORD_W-1:0] held_y [N_CONTACTS];
    slot_t              slots_due [$];
    int                 errors;

    function new();
      cur_rid = RID_RESET;
      errors = 0;
      foreach (touching[i]) touching[i] = 1'b0;
    endfunction

    function void note_rid(logic [RID_W-1:0] value);
      cur_rid = value;
    endfunction

    function int slots_waiting();
      return slots_due.size();
    endfunction

    function void take_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [TIME_W-1:0] ms);
      slot_t       slot;
      int          live_ids [$];
      logic [31:0] scaled;
      case (cmd)
        CMD_SET: begin
          if (id < N_CONTACTS) begin
            touching[id] = 1'b1;
            held_x[id] = x;
            held_y[id] = y;
          end
        end
        CMD_RELEASE: begin
          if (id < N_CONTACTS) touching[id] = 1'b0;
        end
        CMD_REPORT: begin
          scaled = 32'(ms) * SCAN_SCALE;
          for (int i = 0; i < N_CONTACTS; i++) begin
            if (touching[i]) live_ids.push_back(i);
          end
          for (int s = 0; s < N_CONTACTS; s++) begin
            slot = '0;
            slot.rid = cur_rid;
            slot.units = scaled[TIME_W-1:0];
            slot.count = (live_ids.size() > ACT_SAT) ? ACT_SAT : ACT_W'(live_ids.size());
            slot.last = (s == N_CONTACTS - 1);
            if (s < live_ids.size()) begin
              slot.tip = 1'b1;
              slot.contact = ID_W'(live_ids[s]);
              slot.x = held_x[live_ids[s]];
              slot.y = held_y[live_ids[s]];
            end
            slots_due.push_back(slot);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_slot(slot_t got);
      slot_t want;
      if (slots_due.size() == 0) begin
        $error("slot word with no expectation waiting: %0h", got);
        errors++;
        return;
      end
      want = slots_due.pop_front();
      compare_field("out_report_id", 16'(want.rid), 16'(got.rid));
      compare_field("slot_tip", 16'(want.tip), 16'(got.tip));
      compare_field("slot_contact", 16'(want.contact), 16'(got.contact));
      compare_field("slot_x", want.x, got.x);
      compare_field("slot_y", want.y, got.y);
      compare_field("scan_units", want.units, got.units);
      compare_field("active_count", 16'(want.count), 16'(got.count));
      compare_field("last_slot", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CMD_W-1:0]   cmd_i = '0;
  logic [ID_W-1:0]    contact_id_i = '0;
  logic [COORD_W-1:0] pos_x_i = '0;
  logic [COORD_W-1:0] pos_y_i = '0;
  logic [TIME_W-1:0]  scan_ms_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [RID_W-1:0]   cfg_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [RID_W-1:0]   out_report_id_o;
  logic               slot_tip_o;
  logic [ID_W-1:0]    slot_contact_o;
  logic [COORD_W-1:0] slot_x_o;
  logic [COORD_W-1:0] slot_y_o;
  logic [TIME_W-1:0]  scan_units_o;
  logic [ACT_W-1:0]   active_count_o;
  logic               last_slot_o;

  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 73;
  report_predictor predictor;

  multitouch_report_builder #(
    .MAX_CONTACTS(N_CONTACTS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i(cmd_i),
    .contact_id_i(contact_id_i),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .scan_ms_i(scan_ms_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_report_id_o(out_report_id_o),
    .slot_tip_o(slot_tip_o),
    .slot_contact_o(slot_contact_o),
    .slot_x_o(slot_x_o),
    .slot_y_o(slot_y_o),
    .scan_units_o(scan_units_o),
    .active_count_o(active_count_o),
    .last_slot_o(last_slot_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      predictor.check_slot({out_report_id_o, slot_tip_o, slot_contact_o, slot_x_o,
                            slot_y_o, scan_units_o, active_count_o, last_slot_o});
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [TIME_W-1:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    contact_id_i <= id;
    pos_x_i <= x;
    pos_y_i <= y;
    scan_ms_i <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    predictor.take_word(cmd, id, x, y, ms);
  endtask

  task automatic drain_slots();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predictor.slots_waiting() != 0);
  endtask

  task automatic settle();
    drain_slots();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_rid(logic [RID_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    predictor.note_rid(value);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed_words();
    send_word(CMD_REPORT, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_SET, 8'h00, 16'h0000, 16'h0000, 16'h1234);
    send_word(CMD_SET, 8'h04, 16'hffff, 16'hffff, 16'hffff);
    send_word(CMD_REPORT, 8'hff, 16'hffff, 16'hffff, 16'hffff);
    send_word(CMD_SET, ID_W'(N_CONTACTS), 16'h5555, 16'haaaa, 16'h0000);
    send_word(CMD_SET, 8'hff, 16'h1111, 16'h2222, 16'h0000);
    send_word(CMD_RELEASE, 8'hff, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_RELEASE, ID_W'(N_CONTACTS), 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_UNUSED, 8'h02, 16'h1111, 16'h2222, 16'h3333);
    send_word(CMD_REPORT, 8'h00, 16'h0000, 16'h0000, 16'd6553);
    send_word(CMD_SET, 8'h01, 16'h00ff, 16'hff00, 16'h0000);
    send_word(CMD_SET, 8'h02, 16'h8000, 16'h0001, 16'h0000);
    send_word(CMD_SET, 8'h03, 16'h7fff, 16'hfffe, 16'h0000);
    send_word(CMD_REPORT, 8'h00, 16'h0000, 16'h0000, 16'd6554);
    send_word(CMD_SET, 8'h02, 16'hbeef, 16'hcafe, 16'h0000);
    send_word(CMD_RELEASE, 8'h01, 16'hffff, 16'hffff, 16'hffff);
    send_word(CMD_RELEASE, 8'h01, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_REPORT, 8'h03, 16'h1234, 16'h5678, 16'h0001);
    send_word(CMD_RELEASE, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_RELEASE, 8'h02, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_RELEASE, 8'h03, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_RELEASE, 8'h04, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_REPORT, 8'h00, 16'h0000, 16'h0000, 16'h8000);
    send_word(CMD_SET, 8'h04, 16'h0f0f, 16'hf0f0, 16'h0000);
    send_word(CMD_REPORT, 8'h00, 16'h0000, 16'h0000, 16'h7fff);
  endtask

  task automatic random_words(int target);
    int                 counted;
    int unsigned        pick;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  ms;
    counted = 0;
    while (counted < target) begin
      if ($urandom_range(99) < 2) drain_slots();
      pick = $urandom_range(99);
      if (pick < 45) cmd = CMD_SET;
      else if (pick < 72) cmd = CMD_RELEASE;
      else if (pick < 95) cmd = CMD_REPORT;
      else cmd = CMD_UNUSED;
      id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(255))
                                    : ID_W'($urandom_range(N_CONTACTS - 1));
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      ms = TIME_W'($urandom);
      send_word(cmd, id, x, y, ms);
      counted++;
    end
  endtask

  initial begin
    predictor = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();
    settle();
    load_rid(8'h00);
    random_words(102);
    settle();
    send_idle_pct = 73;
    recv_idle_pct = 15;
    load_rid(8'hff);
    random_words(102);
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_rid(RID_W'($urandom_range(255)));
    random_words(102);
    settle();
    if (predictor.errors == 0 && predictor.slots_waiting() == 0) begin
      $display("tb_multitouch_report_builder: done, clean");
    end else begin
      $display("tb_multitouch_report_builder: done, errors");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb_multitouch_report_builder: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
design/mrb_pkg.sv
design/mrb_ctrl.sv
design/mrb_dp.sv
design/multitouch_report_builder.sv
bench/tb_multitouch_report_builder.sv
